/* hdl/pia_pkg.sv */
package pia_pkg;

    // Field widths
    localparam int MEAS_W     = 16;
    localparam int GAIN_W     = 15;
    localparam int ERR_W      = MEAS_W + 1;
    localparam int TERM_W     = 17;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Shared divider: the quotient of either division fits QUOT_W bits
    localparam int DIVIDEND_W = 36;
    localparam int DIVISOR_W  = 19;
    localparam int QUOT_W     = 24;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SETPOINT      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BAND_UPPER    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BAND_LOWER    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_INTEGRAL_GAIN = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_PERIOD = 3'd4;

    localparam logic [GAIN_W-1:0]    PERIOD_RESET = 15'd1000;
    localparam logic [DIVISOR_W-1:0] STEP_DIVISOR = 19'd100;

    typedef struct packed {
        logic signed [MEAS_W-1:0] setpoint;
        logic signed [MEAS_W-1:0] band_upper;
        logic signed [MEAS_W-1:0] band_lower;
        logic [GAIN_W-1:0]        integral_gain;
        logic [GAIN_W-1:0]        sample_period;
    } cfg_t;

endpackage

/* hdl/pia_cfg_regs.sv */
module pia_cfg_regs import pia_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg, cfg_next;

    // Decode the write; drop writes beyond the register list
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_SETPOINT:      cfg_next.setpoint      = $signed(cfg_wdata[MEAS_W-1:0]);
                CFG_BAND_UPPER:    cfg_next.band_upper    = $signed(cfg_wdata[MEAS_W-1:0]);
                CFG_BAND_LOWER:    cfg_next.band_lower    = $signed(cfg_wdata[MEAS_W-1:0]);
                CFG_INTEGRAL_GAIN: cfg_next.integral_gain = cfg_wdata[GAIN_W-1:0];
                CFG_SAMPLE_PERIOD: cfg_next.sample_period = cfg_wdata[GAIN_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.setpoint      <= '0;
            cfg_reg.band_upper    <= '0;
            cfg_reg.band_lower    <= '0;
            cfg_reg.integral_gain <= '0;
            cfg_reg.sample_period <= PERIOD_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/pia_divider.sv */
module pia_divider import pia_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [QUOT_W-1:0]     quotient
);

    localparam int SHIFT_W = DIVISOR_W + QUOT_W - 1;
    localparam int CNT_W   = $clog2(QUOT_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUOT_W - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] rem_reg, rem_next;
    logic [SHIFT_W-1:0]    dsh_reg, dsh_next;
    logic [QUOT_W-1:0]     quo_reg, quo_next;
    logic [SHIFT_W-1:0]    rem_ext;
    logic [SHIFT_W-1:0]    diff;
    logic                  fits;

    // One restoring step: compare against the shifted divisor, subtract if it fits
    assign rem_ext = SHIFT_W'(rem_reg);
    assign fits    = rem_ext >= dsh_reg;
    assign diff    = rem_ext - dsh_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        if (start) begin
            // Load operands, divisor aligned to the top quotient bit
            busy_next = 1'b1;
            cnt_next  = LAST_STEP;
            rem_next  = dividend;
            dsh_next  = {divisor, {(QUOT_W-1){1'b0}}};
            quo_next  = '0;
        end else if (busy_reg) begin
            // Advance one quotient bit
            if (fits) begin
                rem_next = diff[DIVIDEND_W-1:0];
            end
            quo_next = {quo_reg[QUOT_W-2:0], fits};
            dsh_next = dsh_reg >> 1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hdl/pi_integrator_antiwindup_core.sv */
// When integrating, two 24-step passes through the shared restoring divider give the
//   step and then the term, with the upper clamp, or if it does not fire the lower one,
//   between them; zero gain or an out-of-band error clears the accumulator instead.
// No new item is taken until the result moves to the output register, freed by m_ready.
// Reset (aresetn, synchronous, active low): accumulator cleared, registers at
//   their defaults (sample period 1000), no result pending.
module pi_integrator_antiwindup_core import pia_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [MEAS_W-1:0] s_measured_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [TERM_W-1:0] m_integral_term,
    output logic                     m_in_band
);

    // Accumulator stays below 2^35 in magnitude, even before the clamp
    localparam int ACC_W  = 37;
    localparam int MULA_W = ERR_W + 1;
    localparam int PROD_W = MULA_W + GAIN_W + 1;
    localparam int QS_W   = QUOT_W + 1;
    localparam logic signed [ACC_W-1:0] SCALE_STEP = ACC_W'(10);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_STEP,
        S_WAIT_STEP,
        S_MUL_UPPER,
        S_CLAMP_UPPER,
        S_MUL_LOWER,
        S_CLAMP_LOWER,
        S_DIV_TERM,
        S_WAIT_TERM,
        S_DONE
    } state_t;

    cfg_t cfg;

    state_t                   state_reg, state_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     neg_reg, neg_next;
    logic [TERM_W-1:0]        term_reg, term_next;
    logic                     band_reg, band_next;
    logic                     m_valid_reg, m_valid_next;
    logic [TERM_W-1:0]        m_term_reg, m_term_next;
    logic                     m_band_reg, m_band_next;

    logic signed [ERR_W-1:0]  sp_ext, meas_ext, bu_ext, bl_ext;
    logic signed [MULA_W-1:0] err_wide, bu_wide, bl_wide;
    logic signed [MULA_W-1:0] mult_a;
    logic [GAIN_W-1:0]        mult_b;
    logic signed [PROD_W-1:0] mult_out;
    logic                     in_band_chk;
    logic signed [ACC_W-1:0]  lim_ext, lim10, thr;
    logic                     over_upper, under_lower;
    logic [PROD_W-1:0]        prod_abs;
    logic [ACC_W-1:0]         acc_abs;
    logic [DIVISOR_W-1:0]     gain_ext, gain10;
    logic                     div_start, div_done;
    logic [DIVIDEND_W-1:0]    div_dividend;
    logic [DIVISOR_W-1:0]     div_divisor;
    logic [QUOT_W-1:0]        div_quot;
    logic signed [QS_W-1:0]   quot_signed;

    pia_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pia_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Sign-extended operands
    assign sp_ext   = {cfg.setpoint[MEAS_W-1], cfg.setpoint};
    assign meas_ext = {s_measured_value[MEAS_W-1], s_measured_value};
    assign bu_ext   = {cfg.band_upper[MEAS_W-1], cfg.band_upper};
    assign bl_ext   = {cfg.band_lower[MEAS_W-1], cfg.band_lower};
    assign err_wide = {err_reg[ERR_W-1], err_reg};
    assign bu_wide  = {bu_ext[ERR_W-1], bu_ext};
    assign bl_wide  = {bl_ext[ERR_W-1], bl_ext};

    assign in_band_chk = (cfg.integral_gain != '0) && (err_reg >= bl_ext) && (err_reg <= bu_ext);

    // Shared multiplier: error times period, then gain times band distance
    always_comb begin
        case (state_reg)
            S_MUL_UPPER: begin
                mult_a = bu_wide - err_wide;
                mult_b = cfg.integral_gain;
            end
            S_MUL_LOWER: begin
                mult_a = bl_wide - err_wide;
                mult_b = cfg.integral_gain;
            end
            default: begin
                mult_a = err_wide;
                mult_b = cfg.sample_period;
            end
        endcase
    end

    assign mult_out = mult_a * $signed({1'b0, mult_b});

    // Clamp threshold: trunc(acc/10) > lim <=> acc >= 10*lim + 10 (lim >= 0),
    // trunc(acc/10) < lim <=> acc <= 10*lim - 10 (lim <= 0)
    assign lim_ext     = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign lim10       = (lim_ext <<< 3) + (lim_ext <<< 1);
    assign thr         = (state_reg == S_CLAMP_UPPER) ? lim10 + SCALE_STEP : lim10 - SCALE_STEP;
    assign over_upper  = acc_reg >= thr;
    assign under_lower = acc_reg <= thr;

    // Divider operands as magnitudes; sign is restored afterwards
    assign prod_abs  = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign acc_abs   = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign gain_ext  = DIVISOR_W'(cfg.integral_gain);
    assign gain10    = (gain_ext << 3) + (gain_ext << 1);
    assign div_start = (state_reg == S_DIV_STEP) || (state_reg == S_DIV_TERM);

    always_comb begin
        if (state_reg == S_DIV_TERM) begin
            div_dividend = acc_abs[DIVIDEND_W-1:0];
            div_divisor  = gain10;
        end else begin
            div_dividend = {{(DIVIDEND_W-PROD_W){1'b0}}, prod_abs};
            div_divisor  = STEP_DIVISOR;
        end
    end

    assign quot_signed = neg_reg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        err_next     = err_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        term_next    = term_reg;
        band_next    = band_reg;
        m_valid_next = m_valid_reg;
        m_term_next  = m_term_reg;
        m_band_next  = m_band_reg;

        // Drop the result once it has been transferred
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    err_next   = sp_ext - meas_ext;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (in_band_chk) begin
                    prod_next  = mult_out;
                    state_next = S_DIV_STEP;
                end else begin
                    acc_next   = '0;
                    term_next  = '0;
                    band_next  = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_DIV_STEP: begin
                neg_next   = prod_reg[PROD_W-1];
                state_next = S_WAIT_STEP;
            end
            S_WAIT_STEP: begin
                if (div_done) begin
                    acc_next   = acc_reg + ACC_W'(quot_signed);
                    state_next = S_MUL_UPPER;
                end
            end
            S_MUL_UPPER: begin
                prod_next  = mult_out;
                state_next = S_CLAMP_UPPER;
            end
            S_CLAMP_UPPER: begin
                if (over_upper) begin
                    acc_next   = lim10;
                    state_next = S_DIV_TERM;
                end else begin
                    state_next = S_MUL_LOWER;
                end
            end
            S_MUL_LOWER: begin
                prod_next  = mult_out;
                state_next = S_CLAMP_LOWER;
            end
            S_CLAMP_LOWER: begin
                if (under_lower) begin
                    acc_next = lim10;
                end
                state_next = S_DIV_TERM;
            end
            S_DIV_TERM: begin
                neg_next   = acc_reg[ACC_W-1];
                state_next = S_WAIT_TERM;
            end
            S_WAIT_TERM: begin
                if (div_done) begin
                    term_next  = quot_signed[TERM_W-1:0];
                    band_next  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_term_next  = term_reg;
                    m_band_next  = band_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
        err_reg    <= err_next;
        prod_reg   <= prod_next;
        neg_reg    <= neg_next;
        term_reg   <= term_next;
        band_reg   <= band_next;
        m_term_reg <= m_term_next;
        m_band_reg <= m_band_next;
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_integral_term = $signed(m_term_reg);
    assign m_in_band       = m_band_reg;

endmodule
